FILE: hdl/bstb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstb_pkg
// Types, codes and constants shared by the bone modifier blend table.
// ----------------------------------------------------------------------------
package bstb_pkg;

  localparam int MaxEntriesDef = 64;
  localparam logic signed [31:0] QOne = 32'sh0001_0000;
  localparam logic signed [31:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;

  localparam logic [2:0] OpClear = 3'd0;
  localparam logic [2:0] OpAddRot = 3'd1;
  localparam logic [2:0] OpAddScale = 3'd2;
  localparam logic [2:0] OpAddTrans = 3'd3;
  localparam logic [2:0] OpApplyScale = 3'd4;
  localparam logic [2:0] OpApplyTrans = 3'd5;

  localparam logic [1:0] KindRot = 2'd0;
  localparam logic [1:0] KindScale = 2'd1;
  localparam logic [1:0] KindTrans = 2'd2;

  localparam logic CfgGlobalWeight = 1'b0;
  localparam logic CfgCapacity = 1'b1;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] bone;
    logic signed [31:0] weight;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } bstb_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic added;
    logic full_res;
    logic bone_marked;
    logic any_rotation;
    logic any_scale;
    logic any_translation;
  } bstb_out_t;

  // entry record: bone, kind, weight, vector
  typedef struct packed {
    logic [6:0] bone;
    logic [1:0] kind;
    logic signed [31:0] weight;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } bstb_entry_t;

  localparam int EntryW = $bits(bstb_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WMUL,
    ST_STEP1,
    ST_STEP2,
    ST_STEP3,
    ST_DONE
  } bstb_state_t;

  // datapath commands from the controller
  typedef struct packed {
    logic load;
    logic wmul;
    logic step1;
    logic step2;
    logic step3;
    logic next;
    logic emit;
  } bstb_cmd_t;

  typedef struct packed {
    logic is_apply;
    logic scan_end;
    logic hit;
  } bstb_sts_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return SatMax;
    if (x < -64'sd2147483648) return SatMin;
    return x[31:0];
  endfunction

  // floor(a*b/2^16) saturated; the caller passes in the product a*b
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    return sat64(p >>> 16);
  endfunction

endpackage

FILE: hdl/bstb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstb_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module bstb_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
  input  logic [Width-1:0]                            wdata,
  output logic [Width-1:0]                            rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hdl/bstb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstb_ctrl
// Sequencer for clear and add transactions and for table scans during apply transactions.
// ----------------------------------------------------------------------------
module bstb_ctrl
  import bstb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  bstb_sts_t   sts,
  output bstb_cmd_t   cmd
);
  bstb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_DONE;
      ST_DONE:  begin
        if (sts.is_apply && !sts.scan_end) state_nxt = ST_READ;
        else state_nxt = ST_IDLE;
      end
      ST_READ:  state_nxt = ST_WMUL;
      ST_WMUL:  state_nxt = sts.hit ? ST_STEP1 : ST_DONE;
      ST_STEP1: state_nxt = ST_STEP2;
      ST_STEP2: state_nxt = ST_STEP3;
      ST_STEP3: state_nxt = ST_DONE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:  cmd.load = start;
      ST_DONE:  begin
        if (!(sts.is_apply && !sts.scan_end)) cmd.emit = 1'b1;
      end
      ST_READ:  cmd.wmul = 1'b1;
      ST_WMUL:  begin
        cmd.step1 = sts.hit;
        cmd.next = !sts.hit;
      end
      ST_STEP1: cmd.step2 = 1'b1;
      ST_STEP2: cmd.step3 = 1'b1;
      ST_STEP3: cmd.next = 1'b1;
      default:  cmd = '0;
    endcase
  end
endmodule

FILE: hdl/bstb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstb_dp
// Entry table, state registers and blend arithmetic, three lanes.
// ----------------------------------------------------------------------------
module bstb_dp
  import bstb_pkg::*;
#(
  parameter int MaxEntries = MaxEntriesDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bstb_in_t                  in_data,
  input  logic                      cfg_we,
  input  logic                      cfg_sel,
  input  logic [31:0]               cfg_data,
  input  bstb_cmd_t                 cmd,
  output bstb_sts_t                 sts,
  output logic                      out_valid,
  output bstb_out_t                 out_data
);
  localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CW = $clog2(MaxEntries + 1);

  logic signed [31:0] gw_r;
  logic [6:0] cap_r;
  logic [CW-1:0] count_r;
  logic [127:0] mask_r;
  logic [2:0] flags_r;
  bstb_in_t item_r;
  logic [CW-1:0] idx_r;
  logic signed [31:0] v_r [3];
  logic signed [31:0] t_r [3];
  logic signed [63:0] p_r [3];
  logic signed [31:0] w_r;
  logic added_r;
  logic out_valid_r;
  bstb_entry_t rd_e;
  bstb_entry_t wr_e;
  logic [AW-1:0] ram_addr;
  logic ram_we;
  logic [8:0] lim;
  logic can_add;
  logic [1:0] akind;
  logic signed [31:0] ev [3];

  assign lim = ({2'b00, cap_r} < 9'(MaxEntries)) ? {2'b00, cap_r} : 9'(MaxEntries);
  assign can_add = (9'(count_r) < lim);
  assign akind = (item_r.op == OpApplyScale) ? KindScale : KindTrans;
  assign ram_we = cmd.load && (in_data.op == OpAddRot || in_data.op == OpAddScale ||
                  in_data.op == OpAddTrans) && can_add;
  assign ram_addr = ram_we ? count_r[AW-1:0] : idx_r[AW-1:0];
  assign wr_e = '{bone: in_data.bone, kind: 2'(in_data.op - 3'd1), weight: in_data.weight,
                  vx: in_data.vec_x, vy: in_data.vec_y, vz: in_data.vec_z};

  bstb_ram #(.Width(EntryW), .Depth(MaxEntries)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wr_e), .rdata(rd_e)
  );

  assign ev[0] = rd_e.vx;
  assign ev[1] = rd_e.vy;
  assign ev[2] = rd_e.vz;

  assign sts.is_apply = (item_r.op == OpApplyScale) || (item_r.op == OpApplyTrans);
  assign sts.scan_end = (idx_r >= count_r);
  assign sts.hit = (rd_e.bone == item_r.bone) && (rd_e.kind == akind) && (w_r != 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= '0;
      cap_r <= 7'd64;
      count_r <= '0;
      mask_r <= '0;
      flags_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cfg_we) begin
        if (cfg_sel == CfgGlobalWeight) gw_r <= cfg_data;
        else cap_r <= cfg_data[6:0];
      end
      if (cmd.load) begin
        if (in_data.op == OpClear) begin
          count_r <= '0;
          mask_r <= '0;
          flags_r <= '0;
        end else if (ram_we) begin
          count_r <= count_r + 1'b1;
          mask_r[in_data.bone] <= 1'b1;
          flags_r[2'(in_data.op - 3'd1)] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      idx_r <= '0;
      added_r <= ram_we;
      v_r[0] <= in_data.vec_x;
      v_r[1] <= in_data.vec_y;
      v_r[2] <= in_data.vec_z;
    end
    if (cmd.next) idx_r <= idx_r + 1'b1;
    if (cmd.wmul) w_r <= qsat(64'(rd_e.weight) * 64'(gw_r));
    for (int k = 0; k < 3; k++) begin
      if (cmd.step1) begin
        if (w_r < 0) p_r[k] <= 64'(sat64(64'(ev[k]) - 64'(v_r[k]))) *
                               64'(sat64(-64'(w_r)));
        else if (akind == KindScale) p_r[k] <= 64'(sat64(64'(ev[k]) - 64'(QOne))) *
                                              64'(w_r);
        else p_r[k] <= 64'(ev[k]) * 64'(w_r);
      end
      if (cmd.step2) begin
        if (w_r < 0 || akind != KindScale) t_r[k] <= qsat(p_r[k]);
        else t_r[k] <= sat64(64'(QOne) + 64'(qsat(p_r[k])));
      end
      if (cmd.step3) begin
        if (w_r < 0 || akind != KindScale) v_r[k] <= sat64(64'(v_r[k]) + 64'(t_r[k]));
        else v_r[k] <= qsat(64'(v_r[k]) * 64'(t_r[k]));
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = '{out_x: v_r[0], out_y: v_r[1], out_z: v_r[2], added: added_r,
                      full_res: (9'(count_r) >= lim), bone_marked: mask_r[item_r.bone],
                      any_rotation: flags_r[0], any_scale: flags_r[1],
                      any_translation: flags_r[2]};
endmodule

FILE: hdl/bone_scale_translate_blend_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bone_scale_translate_blend_table
// Bone modifier table with Q16.16 scale and translation blending.
// ----------------------------------------------------------------------------
// Clear and add transactions load, then emit from the done state. An apply
// transaction walks every stored entry through the single table read port:
// each entry is read and weighted, and a matching entry then goes through the blend steps.
// out_valid is high for one cycle; the receiver must take it then.
module bone_scale_translate_blend_table
  import bstb_pkg::*;
#(
  parameter int MaxEntries = MaxEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  bstb_in_t    in_data,
  output logic        out_valid,
  output bstb_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  bstb_cmd_t cmd;
  bstb_sts_t sts;

  assign cfg_ready = 1'b1;

  bstb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  bstb_dp #(.MaxEntries(MaxEntries)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_valid && cfg_ready),
    .cfg_sel(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_data(out_data)
  );

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy) else $error("load while busy");
  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !cmd.emit) else $error("double emit");
  a_out_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.emit)) else $error("stray result");
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bone modifier blend table. Builds sequences of
// clear, add and apply transactions with random gaps, reprograms the global
// weight and capacity between phases, and checks every result against an
// in-bench Q16.16 model of the table.
// ----------------------------------------------------------------------------
module tb;
  import bstb_pkg::*;

  typedef struct {
    bit          is_cfg;
    logic        cfg_idx;
    logic [31:0] cfg_val;
    bstb_in_t    item;
  } job_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  bstb_in_t    in_data;
  logic        out_valid;
  bstb_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  bone_scale_translate_blend_table u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  job_t      pend_jobs[$];
  bstb_out_t blend_expect_q[$];
  int        n_miss = 0;
  int        n_items = 0;
  int        n_apply = 0;
  int        n_stored = 0;
  int        n_cfg = 0;
  int        gap_cnt = 0;
  bit        no_idle = 0;

  // model state
  longint       gw_m;
  int           cap_m;
  int           cnt_m;
  logic [6:0]   ent_bone[64];
  logic [1:0]   ent_kind[64];
  longint       ent_w[64];
  longint       ent_v[64][3];
  logic [127:0] mask_m;
  logic [2:0]   flags_m;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fxmul(input longint a, input longint b);
    return clamp32((a * b) >>> 16);
  endfunction

  function automatic longint mix(input longint v, input longint e, input longint w,
                                 input logic [1:0] kind);
    if (w < 0) return clamp32(v + fxmul(clamp32(e - v), clamp32(-w)));
    if (w > 0) begin
      if (kind == KindScale)
        return fxmul(v, clamp32(65536 + fxmul(clamp32(e - 65536), w)));
      return clamp32(v + fxmul(e, w));
    end
    return v;
  endfunction

  task automatic predict_blend(input bstb_in_t it);
    longint    v[3];
    longint    w;
    bstb_out_t r;
    int        lim;
    logic [1:0] kind;
    v[0] = it.vec_x;
    v[1] = it.vec_y;
    v[2] = it.vec_z;
    lim = (cap_m < 64) ? cap_m : 64;
    r = '0;
    n_items++;
    if (it.op == OpClear) begin
      cnt_m = 0;
      mask_m = '0;
      flags_m = '0;
    end else if (it.op == OpAddRot || it.op == OpAddScale || it.op == OpAddTrans) begin
      if (cnt_m < lim) begin
        kind = 2'(it.op - 3'd1);
        ent_bone[cnt_m] = it.bone;
        ent_kind[cnt_m] = kind;
        ent_w[cnt_m] = it.weight;
        ent_v[cnt_m][0] = v[0];
        ent_v[cnt_m][1] = v[1];
        ent_v[cnt_m][2] = v[2];
        cnt_m++;
        mask_m[it.bone] = 1'b1;
        flags_m[kind] = 1'b1;
        r.added = 1'b1;
        n_stored++;
      end
    end else if (it.op == OpApplyScale || it.op == OpApplyTrans) begin
      n_apply++;
      kind = (it.op == OpApplyScale) ? KindScale : KindTrans;
      for (int i = 0; i < cnt_m; i++) begin
        if (ent_bone[i] == it.bone && ent_kind[i] == kind) begin
          w = fxmul(ent_w[i], gw_m);
          for (int c = 0; c < 3; c++) v[c] = mix(v[c], ent_v[i][c], w, kind);
        end
      end
    end
    r.out_x = v[0][31:0];
    r.out_y = v[1][31:0];
    r.out_z = v[2][31:0];
    r.full_res = (cnt_m >= lim);
    r.bone_marked = mask_m[it.bone];
    r.any_rotation = flags_m[KindRot];
    r.any_scale = flags_m[KindScale];
    r.any_translation = flags_m[KindTrans];
    blend_expect_q.push_back(r);
  endtask

  task automatic report_miss(input string fld, input logic [31:0] got, input logic [31:0] exp_v);
    n_miss++;
    $display("error @%0t: %s got %h want %h", $realtime, fld, got, exp_v);
  endtask

  // driver
  always @(posedge clk) begin
    logic nxt_start;
    logic nxt_cfg;
    job_t j;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_cfg = cfg_valid;
      if (start && !busy) begin
        predict_blend(in_data);
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgGlobalWeight) gw_m = $signed(cfg_data);
        else cap_m = cfg_data[6:0];
        n_cfg++;
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg) begin
        if (gap_cnt > 0) gap_cnt--;
        else if (pend_jobs.size() > 0) begin
          j = pend_jobs[0];
          if (j.is_cfg) begin
            if (blend_expect_q.size() == 0 && !busy && !start) begin
              cfg_index <= j.cfg_idx;
              cfg_data <= j.cfg_val;
              nxt_cfg = 1'b1;
              void'(pend_jobs.pop_front());
            end
          end else begin
            in_data <= j.item;
            nxt_start = 1'b1;
            void'(pend_jobs.pop_front());
            if ($urandom_range(0, 49) == 0) no_idle = ~no_idle;
            gap_cnt = no_idle ? 0 : $urandom_range(0, 14);
          end
        end
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // monitor
  always @(posedge clk) begin
    bstb_out_t e;
    if (rst_n && out_valid) begin
      if (blend_expect_q.size() == 0) begin
        report_miss("result with nothing pending", out_data.out_x, 32'h0);
      end else begin
        e = blend_expect_q.pop_front();
        if (out_data.out_x !== e.out_x) report_miss("out_x", out_data.out_x, e.out_x);
        if (out_data.out_y !== e.out_y) report_miss("out_y", out_data.out_y, e.out_y);
        if (out_data.out_z !== e.out_z) report_miss("out_z", out_data.out_z, e.out_z);
        if (out_data.added !== e.added) report_miss("added", out_data.added, e.added);
        if (out_data.full_res !== e.full_res)
          report_miss("full_res", out_data.full_res, e.full_res);
        if (out_data.bone_marked !== e.bone_marked)
          report_miss("bone_marked", out_data.bone_marked, e.bone_marked);
        if (out_data.any_rotation !== e.any_rotation)
          report_miss("any_rotation", out_data.any_rotation, e.any_rotation);
        if (out_data.any_scale !== e.any_scale)
          report_miss("any_scale", out_data.any_scale, e.any_scale);
        if (out_data.any_translation !== e.any_translation)
          report_miss("any_translation", out_data.any_translation, e.any_translation);
      end
    end
  end

  function automatic logic [31:0] pick_q(input int mode);
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return $urandom();
      4: return 32'h0;
      default:
        return mode ? $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000
                    : $signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
    endcase
  endfunction

  task automatic push_item(input logic [2:0] op, input logic [6:0] bone, input logic [31:0] w,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    job_t j;
    j.is_cfg = 0;
    j.cfg_idx = CfgGlobalWeight;
    j.cfg_val = '0;
    j.item.op = op;
    j.item.bone = bone;
    j.item.weight = w;
    j.item.vec_x = x;
    j.item.vec_y = y;
    j.item.vec_z = z;
    pend_jobs.push_back(j);
  endtask

  task automatic push_cfg(input logic idx, input logic [31:0] val);
    job_t j;
    j.is_cfg = 1;
    j.cfg_idx = idx;
    j.cfg_val = val;
    j.item = '0;
    pend_jobs.push_back(j);
  endtask

  task automatic push_rand(input logic [6:0] bone);
    logic [2:0] op;
    op = 3'($urandom_range(1, 5));
    if ($urandom_range(0, 19) == 0) op = 3'($urandom_range(0, 7));
    push_item(op, bone, pick_q(1), pick_q(0), pick_q(0), pick_q(0));
  endtask

  initial begin
    logic [6:0] bones[4];
    int         total;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgGlobalWeight;
    cfg_data = '0;
    gw_m = 0;
    cap_m = 64;
    cnt_m = 0;
    mask_m = '0;
    flags_m = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: weight zero first, then unity, extremes, capacity corners
    push_item(OpAddScale, 7'd5, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h7fff_ffff);
    push_item(OpApplyScale, 7'd5, 32'h0, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff);
    push_cfg(CfgGlobalWeight, 32'h0001_0000);
    push_item(OpAddRot, 7'd127, 32'h7fff_ffff, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff);
    push_item(OpAddTrans, 7'd127, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
    push_item(OpAddTrans, 7'd127, 32'h0000_8000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    push_item(OpApplyTrans, 7'd127, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    push_item(OpApplyScale, 7'd5, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000);
    push_item(OpApplyTrans, 7'd0, 32'hffff_ffff, 32'h1, 32'h2, 32'h3);
    push_item(3'd6, 7'd127, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_item(3'd7, 7'd64, 32'h0, 32'h0, 32'h0, 32'h0);
    push_item(OpClear, 7'd127, 32'h0, 32'h5, 32'h6, 32'h7);
    push_cfg(CfgCapacity, 32'd0);
    push_item(OpAddScale, 7'd1, 32'h0001_0000, 32'h1, 32'h1, 32'h1);
    push_cfg(CfgCapacity, 32'd127);
    push_cfg(CfgGlobalWeight, 32'h8000_0000);
    for (int i = 0; i < 64; i++)
      push_item(3'(OpAddRot + (i % 3)), i[6:0] & 7'd3, pick_q(1), pick_q(0), pick_q(0),
                pick_q(0));
    push_item(OpAddScale, 7'd2, 32'h1, 32'h1, 32'h1, 32'h1);
    push_item(OpApplyScale, 7'd1, 32'h0, 32'h0001_8000, 32'hfffe_0000, 32'h0000_4000);
    push_item(OpApplyTrans, 7'd2, 32'h0, 32'h0001_8000, 32'hfffe_0000, 32'h0000_4000);
    push_cfg(CfgCapacity, 32'd4);
    push_item(OpApplyTrans, 7'd0, 32'h0, 32'h1, 32'h0, 32'h0);
    push_item(OpAddTrans, 7'd9, 32'h1, 32'h1, 32'h1, 32'h1);

    // random phases: clear in most phases, build a small table, apply to its bones
    total = 0;
    while (total < 420) begin
      push_cfg(CfgGlobalWeight, pick_q(1));
      case ($urandom_range(0, 5))
        0: push_cfg(CfgCapacity, 32'd64);
        1: push_cfg(CfgCapacity, $urandom_range(0, 3));
        2: push_cfg(CfgCapacity, $urandom_range(65, 127));
        default: push_cfg(CfgCapacity, $urandom_range(4, 24));
      endcase
      for (int b = 0; b < 4; b++) bones[b] = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 3) != 0) begin
        push_item(OpClear, bones[0], pick_q(1), pick_q(0), pick_q(0), pick_q(0));
        total++;
      end
      for (int k = 0; k < 40; k++) begin
        if ($urandom_range(0, 9) == 0) push_rand(7'($urandom_range(0, 127)));
        else push_rand(bones[$urandom_range(0, 3)]);
        total++;
      end
    end

    while (pend_jobs.size() > 0 || blend_expect_q.size() > 0 || start || cfg_valid)
      @(posedge clk);
    repeat (500) @(posedge clk);
    $display("ran %0d transactions: %0d applies, %0d entries stored, %0d register writes",
             n_items, n_apply, n_stored, n_cfg);
    if (n_miss == 0) begin
      $display("bone_scale_translate_blend_table: match");
    end else begin
      $display("bone_scale_translate_blend_table: mismatch");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout with %0d results outstanding", blend_expect_q.size());
    $display("bone_scale_translate_blend_table: mismatch");
    $finish;
  end

endmodule
